FILE: hdl/sxb_pkg.sv
// Shared types and constants for the sparse-vector permute/xor bind unit.
// Used by every module under hdl/.
package sxb_pkg;

  localparam int VEC_BITS  = 2048;
  localparam int BLK_W     = 64;
  localparam int NBLK      = VEC_BITS / BLK_W;
  localparam int IDX_W     = 11;
  localparam int BIDX_W    = 5;
  localparam int BIT_W     = $clog2(BLK_W);
  localparam int CNT_W     = IDX_W + 1;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [1:0] REQ_TBL = 2'd0;
  localparam logic [1:0] REQ_OPA = 2'd1;
  localparam logic [1:0] REQ_OPB = 2'd2;
  localparam logic [1:0] REQ_CMP = 2'd3;

  localparam logic [1:0] MODE_BIND = 2'd0;
  localparam logic [1:0] MODE_UNB1 = 2'd1;
  localparam logic [1:0] MODE_UNB2 = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [1:0] TBL_S    = 2'd0;
  localparam logic [1:0] TBL_SINV = 2'd1;
  localparam logic [1:0] TBL_P    = 2'd2;
  localparam logic [1:0] TBL_PINV = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        sel;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  val;
    logic [BIDX_W-1:0] bidx;
    logic [BLK_W-1:0]  data;
    logic [1:0]        mode;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

endpackage

FILE: hdl/sxb_front.sv
// Front end: accepts items and drops those that have no effect.
// Depends on sxb_pkg.
module sxb_front import sxb_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [1:0]         in_table_select,
  input  logic [IDX_W-1:0]   in_table_index,
  input  logic [IDX_W-1:0]   in_table_value,
  input  logic [BIDX_W-1:0]  in_block_index,
  input  logic [BLK_W-1:0]   in_block_data,
  input  logic [1:0]         in_op_mode,
  input  logic               q_full,
  output logic               q_push,
  output req_t               q_data
);

  logic keep;

  assign in_ready = ~q_full;

  always_comb begin
    unique case (in_req_type)
      REQ_TBL: keep = ({1'b0, in_table_index} < CNT_W'(VEC_BITS));
      REQ_OPA, REQ_OPB: keep = ({1'b0, in_block_index} < (BIDX_W+1)'(NBLK));
      REQ_CMP: keep = (in_op_mode != MODE_BAD);
      default: keep = 1'b0;
    endcase
  end

  assign q_push      = in_valid & in_ready & keep;
  assign q_data.kind = in_req_type;
  assign q_data.sel  = in_table_select;
  assign q_data.idx  = in_table_index;
  assign q_data.val  = in_table_value;
  assign q_data.bidx = in_block_index;
  assign q_data.data = in_block_data;
  assign q_data.mode = in_op_mode;

endmodule

FILE: hdl/sxb_queue.sv
// Short request queue between front and back end.
// Depends on sxb_pkg.
module sxb_queue import sxb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  req_t   push_data,
  output logic   full,
  input  logic   pop,
  output qhead_t head
);

  req_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.req   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

FILE: hdl/sxb_back.sv
// Back end: table/operand stores, the bit walk and the result stream.
// Depends on sxb_pkg.
module sxb_back import sxb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  qhead_t            head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BIDX_W-1:0] out_block_index,
  output logic [BLK_W-1:0]  out_block_data,
  output logic              out_last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK1 = 4'b0010,
    ST_WALK2 = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] tbl_s   [VEC_BITS];
  logic [IDX_W-1:0] tbl_si  [VEC_BITS];
  logic [IDX_W-1:0] tbl_p   [VEC_BITS];
  logic [IDX_W-1:0] tbl_pi  [VEC_BITS];
  logic [IDX_W-1:0] s_q, si_q, p_q, pi_q;

  logic [BLK_W-1:0] opa_r [NBLK];
  logic [BLK_W-1:0] opb_r [NBLK];
  logic [BLK_W-1:0] wa_r  [NBLK];
  logic [BLK_W-1:0] wb_r  [NBLK];

  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        mode_r;
  logic [BIDX_W-1:0] k_r;
  logic              pv_r, pbit1_r, pbita_r;
  logic              ov_r, olast_r;
  logic [BIDX_W-1:0] oidx_r;
  logic [BLK_W-1:0]  odata_r;

  logic              walking, issue, walk_done, slot_free, tbl_we;
  logic [IDX_W-1:0]  rd_addr, t1, t2;
  logic [BIDX_W-1:0] blk_addr;
  logic [BIT_W-1:0]  bit_sel;
  logic [BLK_W-1:0]  a_blk, b_blk, wa_blk, wb_blk;
  logic              src1, srca;

  assign walking   = (state_r == ST_WALK1) || (state_r == ST_WALK2);
  assign issue     = walking && (cnt_r < CNT_W'(VEC_BITS));
  assign walk_done = walking && !issue && !pv_r;
  assign slot_free = !ov_r || out_ready;
  assign rd_addr   = cnt_r[IDX_W-1:0];
  assign bit_sel   = cnt_r[BIT_W-1:0];
  assign blk_addr  = (state_r == ST_EMIT) ? k_r : cnt_r[IDX_W-1:BIT_W];
  assign a_blk     = opa_r[blk_addr];
  assign b_blk     = opb_r[blk_addr];
  assign wa_blk    = wa_r[blk_addr];
  assign wb_blk    = wb_r[blk_addr];

  // first walk scatters B; second walk scatters (wb ^ A)
  assign src1 = (state_r == ST_WALK2) ? (wb_blk[bit_sel] ^ a_blk[bit_sel]) : b_blk[bit_sel];
  assign srca = a_blk[bit_sel];
  assign t1   = (mode_r == MODE_UNB2) ? s_q : p_q;
  assign t2   = (mode_r == MODE_UNB1) ? si_q : pi_q;

  assign pop    = (state_r == ST_IDLE) && head.valid;
  assign tbl_we = pop && (head.req.kind == REQ_TBL);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (pop && head.req.kind == REQ_CMP) state_nxt = ST_WALK1;
      ST_WALK1: if (walk_done) state_nxt = (mode_r == MODE_BIND) ? ST_EMIT : ST_WALK2;
      ST_WALK2: if (walk_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (slot_free && k_r == BIDX_W'(NBLK-1)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
      if (issue) cnt_r <= cnt_r + 1'b1;
      else if (walk_done) cnt_r <= '0;
      if (state_r == ST_EMIT && slot_free) k_r <= k_r + 1'b1;
      if (state_r == ST_EMIT && slot_free) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // table memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (tbl_we && head.req.sel == TBL_S) tbl_s[head.req.idx] <= head.req.val;
    if (tbl_we && head.req.sel == TBL_SINV) tbl_si[head.req.idx] <= head.req.val;
    if (tbl_we && head.req.sel == TBL_P) tbl_p[head.req.idx] <= head.req.val;
    if (tbl_we && head.req.sel == TBL_PINV) tbl_pi[head.req.idx] <= head.req.val;
    s_q  <= tbl_s[rd_addr];
    si_q <= tbl_si[rd_addr];
    p_q  <= tbl_p[rd_addr];
    pi_q <= tbl_pi[rd_addr];
  end

  always_ff @(posedge clk) begin
    pbit1_r <= src1;
    pbita_r <= srca;
    if (pop && head.req.kind == REQ_OPA) opa_r[head.req.bidx] <= head.req.data;
    if (pop && head.req.kind == REQ_OPB) opb_r[head.req.bidx] <= head.req.data;
    if (pop && head.req.kind == REQ_CMP) begin
      mode_r <= head.req.mode;
      for (int i = 0; i < NBLK; i++) begin
        wa_r[i] <= '0;
        wb_r[i] <= '0;
      end
    end
    if (pv_r && state_r == ST_WALK1) begin
      if (pbit1_r && ({1'b0, t1} < CNT_W'(VEC_BITS)))
        wb_r[t1[IDX_W-1:BIT_W]][t1[BIT_W-1:0]] <= 1'b1;
      if (mode_r == MODE_BIND && pbita_r && ({1'b0, s_q} < CNT_W'(VEC_BITS)))
        wa_r[s_q[IDX_W-1:BIT_W]][s_q[BIT_W-1:0]] <= 1'b1;
    end
    if (pv_r && state_r == ST_WALK2 && pbit1_r && ({1'b0, t2} < CNT_W'(VEC_BITS)))
      wa_r[t2[IDX_W-1:BIT_W]][t2[BIT_W-1:0]] <= 1'b1;
    if (state_r == ST_EMIT && slot_free) begin
      oidx_r  <= k_r;
      odata_r <= (mode_r == MODE_BIND) ? (wa_blk ^ wb_blk) : wa_blk;
      olast_r <= (k_r == BIDX_W'(NBLK-1));
    end
  end

  assign out_valid       = ov_r;
  assign out_block_index = oidx_r;
  assign out_block_data  = odata_r;
  assign out_last        = olast_r;

endmodule

FILE: hdl/sdr_permute_xor_bind_unbind_top.sv
// Top level of the sparse-vector permute/xor bind and unbind unit.
// Depends on sxb_pkg, sxb_front, sxb_queue and sxb_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   in      | input     | in_valid / in_ready  | req type, table entry, block, mode
//   out     | output    | out_valid/out_ready  | block index, block data, last
//
// Loads (table entries, operand blocks) retire one item per cycle in ST_IDLE.
// A compute walks all 2048 source bits once per pass, one bit per cycle
// through the table read port: bind takes one pass, the unbind modes two;
// then 32 result items stream out, one per cycle while out_ready is high.
// Reset (rst_n low, synchronous) clears control only; stores start undefined.
// A four-entry queue lets the input keep accepting while the back end is busy
// or the output is stalled; in_ready drops only when that queue is full.
module sdr_permute_xor_bind_unbind_top import sxb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [1:0]        in_table_select,
  input  logic [IDX_W-1:0]  in_table_index,
  input  logic [IDX_W-1:0]  in_table_value,
  input  logic [BIDX_W-1:0] in_block_index,
  input  logic [BLK_W-1:0]  in_block_data,
  input  logic [1:0]        in_op_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BIDX_W-1:0] out_block_index,
  output logic [BLK_W-1:0]  out_block_data,
  output logic              out_last
);

  logic   q_full, q_push, q_pop;
  req_t   q_data;
  qhead_t q_head;

  // classify and drop no-op items
  sxb_front u_front (
    .in_valid, .in_ready, .in_req_type, .in_table_select,
    .in_table_index, .in_table_value, .in_block_index, .in_block_data,
    .in_op_mode, .q_full, .q_push, .q_data
  );

  sxb_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .head(q_head)
  );

  // stores, bit walk and output register
  sxb_back u_back (
    .clk, .rst_n, .head(q_head), .pop(q_pop), .out_valid, .out_ready,
    .out_block_index, .out_block_data, .out_last
  );

endmodule
